### rtl/pwrwe_pkg.sv
// pwrwe_pkg: shared types and constants of the pulse-width register write encoder
// word layouts, configuration set, segment kinds and register indexes
// no dependencies
package pwrwe_pkg;

  localparam int unsigned FrameBits = 24;
  localparam int unsigned SegBits   = 6;

  // segment kinds as carried in segment_kind
  localparam logic [2:0] KIND_PRE   = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_SPACE = 3'd2;
  localparam logic [2:0] KIND_BIT   = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;
  localparam logic [2:0] KIND_POST  = 3'd5;

  // segment positions within one frame
  localparam logic [SegBits-1:0] SEG_PRE       = 6'd0;
  localparam logic [SegBits-1:0] SEG_START     = 6'd1;
  localparam logic [SegBits-1:0] SEG_LEAD_GAP  = 6'd2;
  localparam logic [SegBits-1:0] SEG_FIRST_BIT = 6'd3;
  localparam logic [SegBits-1:0] SEG_STOP      = 6'd51;
  localparam logic [SegBits-1:0] SEG_LAST      = 6'd52;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_ZERO_PULSE     = 3'd1;
  localparam logic [2:0] REG_ONE_PULSE      = 3'd2;
  localparam logic [2:0] REG_SPACE          = 3'd3;
  localparam logic [2:0] REG_START          = 3'd4;
  localparam logic [2:0] REG_STOP           = 3'd5;
  localparam logic [2:0] REG_PRE            = 3'd6;
  localparam logic [2:0] REG_POST           = 3'd7;

  // reset values of the configuration registers
  localparam logic [6:0] RST_DEVICE_ADDRESS = 7'd83;
  localparam logic [7:0] RST_ZERO_PULSE     = 8'd10;
  localparam logic [7:0] RST_ONE_PULSE      = 8'd30;
  localparam logic [7:0] RST_SPACE          = 8'd10;
  localparam logic [7:0] RST_START          = 8'd10;
  localparam logic [7:0] RST_STOP           = 8'd130;
  localparam logic [7:0] RST_PRE            = 8'd60;
  localparam logic [7:0] RST_POST           = 8'd60;

  typedef struct packed {
    logic [7:0] target_register;
    logic [7:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic       select_level;
    logic [7:0] segment_cycles;
    logic [2:0] segment_kind;
    logic       last_segment;
  } out_word_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] zero_pulse_cycles;
    logic [7:0] one_pulse_cycles;
    logic [7:0] space_cycles;
    logic [7:0] start_cycles;
    logic [7:0] stop_cycles;
    logic [7:0] pre_cycles;
    logic [7:0] post_cycles;
  } cfg_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/pwrwe_front.sv
// pwrwe_front: accepts write requests and frames address, register and data
// into one 24-bit word held until the queue takes it
// depends on pwrwe_pkg
module pwrwe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pwrwe_pkg::in_word_t                 in_word,
  input  logic [6:0]                          device_address,
  input  pwrwe_pkg::q_status_t                q_status,
  output logic                                push,
  output logic [pwrwe_pkg::FrameBits-1:0]     push_frame
);

  logic                              frame_valid_r;
  logic                              frame_valid_nxt;
  logic [pwrwe_pkg::FrameBits-1:0]   frame_r;
  logic                              take;

  assign in_stall   = frame_valid_r && q_status.full;
  assign take       = in_valid && !in_stall;
  assign push       = frame_valid_r && !q_status.full;
  assign push_frame = frame_r;

  always_comb begin
    frame_valid_nxt = frame_valid_r;
    if (push) begin
      frame_valid_nxt = 1'b0;
    end
    if (take) begin
      frame_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
    end else begin
      frame_valid_r <= frame_valid_nxt;
    end
  end

  // address with write bit zero, then register, then data
  always_ff @(posedge clk) begin
    if (take) begin
      frame_r <= {device_address, 1'b0, in_word.target_register, in_word.write_value};
    end
  end

endmodule

### rtl/pwrwe_queue.sv
// pwrwe_queue: small first-in first-out queue of framed words between front and back
// depends on pwrwe_pkg
module pwrwe_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [pwrwe_pkg::FrameBits-1:0]     push_frame,
  input  logic                                pop,
  output logic [pwrwe_pkg::FrameBits-1:0]     pop_frame,
  output pwrwe_pkg::q_status_t                q_status
);

  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] PtrMax = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(Depth);

  logic [pwrwe_pkg::FrameBits-1:0] entries_r [Depth];
  logic [PtrBits-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0]              count_r, count_nxt;
  logic                            do_push, do_pop;

  assign q_status.full  = (count_r == CntFull);
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_frame      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

### rtl/pwrwe_back.sv
// pwrwe_back: segment sequencer, walks 53 segments per framed word into the output register
// depends on pwrwe_pkg
module pwrwe_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pwrwe_pkg::cfg_t                     cfg,
  input  pwrwe_pkg::q_status_t                q_status,
  input  logic [pwrwe_pkg::FrameBits-1:0]     pop_frame,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pwrwe_pkg::out_word_t                out_word
);

  logic                                busy_r, busy_nxt;
  logic [pwrwe_pkg::SegBits-1:0]       seg_r, seg_nxt;
  logic [pwrwe_pkg::FrameBits-1:0]     frame_r, frame_nxt;
  logic                                out_valid_r, out_valid_nxt;
  pwrwe_pkg::out_word_t                out_word_r;
  pwrwe_pkg::out_word_t                seg_word;
  logic                                advance, finishing, is_bit;

  assign advance   = !out_valid_r || !out_stall;
  assign finishing = busy_r && (seg_r == pwrwe_pkg::SEG_LAST);
  assign pop       = advance && !q_status.empty && (!busy_r || finishing);
  // bit pulses sit at the odd positions between the lead gap and the stop
  assign is_bit    = (seg_r >= pwrwe_pkg::SEG_FIRST_BIT) && (seg_r < pwrwe_pkg::SEG_STOP)
                     && seg_r[0];

  always_comb begin
    seg_word = '0;
    case (seg_r)
      pwrwe_pkg::SEG_PRE: begin
        seg_word.segment_cycles = cfg.pre_cycles;
        seg_word.segment_kind   = pwrwe_pkg::KIND_PRE;
      end
      pwrwe_pkg::SEG_START: begin
        seg_word.select_level   = 1'b1;
        seg_word.segment_cycles = cfg.start_cycles;
        seg_word.segment_kind   = pwrwe_pkg::KIND_START;
      end
      pwrwe_pkg::SEG_STOP: begin
        seg_word.select_level   = 1'b1;
        seg_word.segment_cycles = cfg.stop_cycles;
        seg_word.segment_kind   = pwrwe_pkg::KIND_STOP;
      end
      pwrwe_pkg::SEG_LAST: begin
        seg_word.segment_cycles = cfg.post_cycles;
        seg_word.segment_kind   = pwrwe_pkg::KIND_POST;
        seg_word.last_segment   = 1'b1;
      end
      default: begin
        if (is_bit) begin
          seg_word.select_level   = 1'b1;
          seg_word.segment_cycles = frame_r[pwrwe_pkg::FrameBits-1] ? cfg.one_pulse_cycles
                                                                   : cfg.zero_pulse_cycles;
          seg_word.segment_kind   = pwrwe_pkg::KIND_BIT;
        end else begin
          seg_word.segment_cycles = cfg.space_cycles;
          seg_word.segment_kind   = pwrwe_pkg::KIND_SPACE;
        end
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    seg_nxt       = seg_r;
    frame_nxt     = frame_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        seg_nxt = seg_r + 1'b1;
        if (is_bit) begin
          frame_nxt = frame_r << 1;
        end
      end
      if (finishing) begin
        busy_nxt = 1'b0;
        seg_nxt  = '0;
      end
      if (pop) begin
        busy_nxt  = 1'b1;
        seg_nxt   = '0;
        frame_nxt = pop_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (advance && busy_r) begin
      out_word_r <= seg_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/pulse_width_register_write_encoder_unit.sv
// throughput: 53 segment words per request, one per cycle while not stalled, paced by the
//   back sequencer's segment counter; back-to-back requests follow with no gap once queued
// reset (rst_n low, synchronous): config registers to defaults, queue emptied, no output word
// top level: config registers, front framer, queue, back sequencer; depends on pwrwe_pkg
module pulse_width_register_write_encoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pwrwe_pkg::in_word_t   in_word,
  // segment channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output pwrwe_pkg::out_word_t  out_word,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);

  pwrwe_pkg::cfg_t                  cfg_r, cfg_nxt;
  pwrwe_pkg::q_status_t             q_status;
  logic                             push, pop;
  logic [pwrwe_pkg::FrameBits-1:0]  push_frame, pop_frame;

  // register write decode, only low bits kept for the address register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pwrwe_pkg::REG_DEVICE_ADDRESS: cfg_nxt.device_address    = cfg_wdata[6:0];
        pwrwe_pkg::REG_ZERO_PULSE:     cfg_nxt.zero_pulse_cycles = cfg_wdata;
        pwrwe_pkg::REG_ONE_PULSE:      cfg_nxt.one_pulse_cycles  = cfg_wdata;
        pwrwe_pkg::REG_SPACE:          cfg_nxt.space_cycles      = cfg_wdata;
        pwrwe_pkg::REG_START:          cfg_nxt.start_cycles      = cfg_wdata;
        pwrwe_pkg::REG_STOP:           cfg_nxt.stop_cycles       = cfg_wdata;
        pwrwe_pkg::REG_PRE:            cfg_nxt.pre_cycles        = cfg_wdata;
        pwrwe_pkg::REG_POST:           cfg_nxt.post_cycles       = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= pwrwe_pkg::RST_DEVICE_ADDRESS;
      cfg_r.zero_pulse_cycles <= pwrwe_pkg::RST_ZERO_PULSE;
      cfg_r.one_pulse_cycles  <= pwrwe_pkg::RST_ONE_PULSE;
      cfg_r.space_cycles      <= pwrwe_pkg::RST_SPACE;
      cfg_r.start_cycles      <= pwrwe_pkg::RST_START;
      cfg_r.stop_cycles       <= pwrwe_pkg::RST_STOP;
      cfg_r.pre_cycles        <= pwrwe_pkg::RST_PRE;
      cfg_r.post_cycles       <= pwrwe_pkg::RST_POST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: takes a request word and frames it, holds it while the queue is full
  pwrwe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .device_address (cfg_r.device_address),
    .q_status       (q_status),
    .push           (push),
    .push_frame     (push_frame)
  );

  // queue decouples framing from segment output
  pwrwe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .q_status   (q_status)
  );

  // back: one segment word per cycle into the output register while not stalled, next frame
  // loaded in the same cycle as the post-clock segment
  pwrwe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .pop_frame (pop_frame),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### rtl/pwrwe_checker.sv
// pwrwe_checker: port-level checks of the pulse-width register write encoder
// bound to pulse_width_register_write_encoder_unit; depends on pwrwe_pkg
module pwrwe_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input pwrwe_pkg::out_word_t  out_word
);

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // a stalled segment word is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // only the post-clock segment closes a frame
  a_last_post: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last_segment == (out_word.segment_kind == pwrwe_pkg::KIND_POST)))
    else $error("last flag and post-clock kind disagree");

  // line high exactly on start, bit pulse and stop
  a_level_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.select_level == ((out_word.segment_kind == pwrwe_pkg::KIND_START)
      || (out_word.segment_kind == pwrwe_pkg::KIND_BIT)
      || (out_word.segment_kind == pwrwe_pkg::KIND_STOP))))
    else $error("select level does not match segment kind");

  // a post-clock segment taken is followed by a pre-clock or by nothing
  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_word.last_segment
    |=> !out_valid || (out_word.segment_kind == pwrwe_pkg::KIND_PRE))
    else $error("frame did not restart with a pre-clock segment");

endmodule

bind pulse_width_register_write_encoder_unit pwrwe_checker u_pwrwe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
